[rtl/core/rice_block_decoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Rice block decoder
// Define NO_ASSERTIONS to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef RICE_BLOCK_DECODER_UNIT_DEFINES_SVH
`define RICE_BLOCK_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define RBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbd check failed");
// antecedent implies consequent in the next cycle
`define RBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbd check failed");
`else
`define RBD_ASSERT_NOW(label, ante, cons)
`define RBD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/core/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg
// Types and constants shared by the Rice block decoder.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int BLOCK_SIZE_DEF   = 16;
  localparam int REF_BITS_DEF     = 12;
  localparam int CODE_ID_BITS_DEF = 4;
  localparam int WORD_BITS_DEF    = 16;

  localparam int SAMPLE_W = 12;
  localparam int MAP_W    = 16;

  localparam logic [3:0]       SB_MIN   = 4'd8;
  localparam logic [3:0]       SB_MAX   = 4'd12;
  localparam logic [3:0]       SB_RESET = 4'd12;
  localparam logic [MAP_W-1:0] RUN_MAX  = 16'hFFFF;

  localparam logic REG_SAMPLE_BITS = 1'b0;

  typedef enum logic [2:0] {
    PH_REF,
    PH_CODE,
    PH_BACKUP,
    PH_FS,
    PH_SPLIT
  } phase_t;

endpackage

[rtl/core/rbd_unmap.sv]
// ----------------------------------------------------------------------------
// rbd_unmap
// Inverse prediction mapper: one mapped value against the running sample.
// ----------------------------------------------------------------------------
module rbd_unmap (
  input  logic [rbd_pkg::MAP_W-1:0]    mapped,
  input  logic [rbd_pkg::SAMPLE_W-1:0] prev,
  input  logic [rbd_pkg::SAMPLE_W-1:0] top,
  output logic [rbd_pkg::SAMPLE_W-1:0] sample
);
  import rbd_pkg::*;

  logic [SAMPLE_W-1:0] theta;
  logic [SAMPLE_W-1:0] room;
  logic [MAP_W:0]      half_odd;
  logic [MAP_W-1:0]    d;
  logic [MAP_W-1:0]    dd;
  logic                in_rng;
  logic [MAP_W:0]      r;

  always_comb begin
    room     = top - prev;
    theta    = (prev < room) ? prev : room;
    half_odd = ({1'b0, mapped} + 17'd1) >> 1;
    d        = mapped[0] ? half_odd[MAP_W-1:0] : {1'b0, mapped[MAP_W-1:1]};
    in_rng   = d <= {{(MAP_W-SAMPLE_W){1'b0}}, theta};
    dd       = mapped - {{(MAP_W-SAMPLE_W){1'b0}}, theta};
    if (in_rng) begin
      r = mapped[0] ? {5'd0, prev} + {1'b0, d} : {5'd0, prev} - {1'b0, d};
    end else begin
      // folded region: direction set by which edge theta came from
      r = (theta == prev) ? {5'd0, prev} + {1'b0, dd} : {5'd0, prev} - {1'b0, dd};
    end
    sample = r[SAMPLE_W-1:0] & top;
  end

endmodule

[rtl/core/rice_block_decoder_unit.sv]
// ----------------------------------------------------------------------------
// rice_block_decoder_unit
// Bit-serial Rice block decoder with prediction unmapping.
// ----------------------------------------------------------------------------
// Each accepted word is consumed one bit per cycle, MSB first. When a block
// completes, bit decoding pauses while its BLOCK_SIZE samples are unmapped and
// emitted at one per cycle (longer under output back-pressure); the next word
// is taken once both are done. Mapped values sit in a rotating shift line read
// at its head and written at its tail.
`include "rice_block_decoder_unit_defines.svh"
module rice_block_decoder_unit #(
  parameter int BLOCK_SIZE   = rbd_pkg::BLOCK_SIZE_DEF,
  parameter int REF_BITS     = rbd_pkg::REF_BITS_DEF,
  parameter int CODE_ID_BITS = rbd_pkg::CODE_ID_BITS_DEF,
  parameter int WORD_BITS    = rbd_pkg::WORD_BITS_DEF,
  parameter int IN_TDATA_W   = ((WORD_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // word
  input  logic                  in_tlast,   // final_word
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // sample
  output logic                  out_tuser,  // block_end
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import rbd_pkg::*;

  localparam int BC_W = $clog2(REF_BITS + 1);
  localparam int SI_W = $clog2(BLOCK_SIZE);
  localparam int WB_W = $clog2(WORD_BITS);

  // configuration
  logic [3:0] sb_r, sb_nxt;
  logic [3:0] eff_w;
  logic [SAMPLE_W-1:0] top_mask;

  // word feed
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [WB_W-1:0]      wcnt_r, wcnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 fin_r, fin_nxt;

  // decode state
  phase_t               phase_r, phase_nxt;
  logic [BC_W-1:0]      bc_r, bc_nxt;
  logic [MAP_W-1:0]     acc_r, acc_nxt;
  logic [CODE_ID_BITS-1:0] code_r, code_nxt;
  logic [SI_W-1:0]      si_r, si_nxt;
  logic [3:0]           plane_r, plane_nxt;
  logic [MAP_W-1:0]     run_r, run_nxt;
  logic [SAMPLE_W-1:0]  prev_r, prev_nxt;

  // emission
  logic                 emit_r, emit_nxt;
  logic [SI_W-1:0]      eidx_r, eidx_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [SAMPLE_W-1:0]  osample_r, osample_nxt;
  logic                 oend_r, oend_nxt;

  // mapped value line, head at index 0
  logic [MAP_W-1:0] line_r [BLOCK_SIZE];
  logic             adv;
  logic [MAP_W-1:0] adv_val;

  logic             bit_in;
  logic             step;
  logic             slot;
  logic             fin_block;
  logic [3:0]       k;
  logic [3:0]       pos;
  logic [MAP_W-1:0] acc_sh;
  logic [SAMPLE_W-1:0] unmapped;
  logic             si_last;

  always_comb begin
    if (sb_r < SB_MIN) eff_w = SB_MIN;
    else if (sb_r > SB_MAX) eff_w = SB_MAX;
    else eff_w = sb_r;
    top_mask = SAMPLE_W'((13'd1 << eff_w) - 13'd1);
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SAMPLE_BITS) ? {28'd0, sb_r} : 32'd0;
  always_comb begin
    sb_nxt = sb_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_SAMPLE_BITS)
      sb_nxt = cfg_pwdata[3:0];
  end

  rbd_unmap u_unmap (
    .mapped (line_r[0]),
    .prev   (prev_r),
    .top    (top_mask),
    .sample (unmapped)
  );

  assign in_tready  = !busy_r && !emit_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(16-SAMPLE_W){1'b0}}, osample_r};
  assign out_tuser  = oend_r;

  assign slot    = !ovalid_r || out_tready;
  assign step    = busy_r && !emit_r;
  assign bit_in  = word_r[WORD_BITS-1];
  assign k       = 4'(code_r);
  assign pos     = k - 4'd1 - plane_r;
  assign acc_sh  = {acc_r[MAP_W-2:0], bit_in};
  assign si_last = si_r == SI_W'(BLOCK_SIZE - 1);

  // next-state logic of the decode phase
  always_comb begin
    phase_nxt = phase_r;
    fin_block = 1'b0;
    if (step) begin
      case (phase_r)
        PH_REF: begin
          if (bc_r + 1'b1 >= BC_W'(REF_BITS)) phase_nxt = PH_CODE;
        end
        PH_CODE: begin
          if (bc_r + 1'b1 >= BC_W'(CODE_ID_BITS))
            phase_nxt = (6'(acc_sh[CODE_ID_BITS-1:0]) >= 6'(eff_w)) ?
                        PH_BACKUP : PH_FS;
        end
        PH_BACKUP: begin
          if (bc_r + 1'b1 >= BC_W'(eff_w) && si_last) fin_block = 1'b1;
        end
        PH_FS: begin
          if (bit_in && si_last) begin
            if (code_r == '0) fin_block = 1'b1;
            else phase_nxt = PH_SPLIT;
          end
        end
        PH_SPLIT: begin
          if (si_last && 5'(plane_r) + 5'd1 >= 5'(code_r)) fin_block = 1'b1;
        end
        default: phase_nxt = PH_REF;
      endcase
      if (fin_block) phase_nxt = PH_CODE;
      if (wcnt_r == '0 && fin_r) phase_nxt = PH_REF;
    end
  end

  // datapath of the decode phase, word feed and emission outputs
  always_comb begin
    bc_nxt    = bc_r;
    acc_nxt   = acc_r;
    code_nxt  = code_r;
    si_nxt    = si_r;
    plane_nxt = plane_r;
    run_nxt   = run_r;
    prev_nxt  = prev_r;
    adv       = 1'b0;
    adv_val   = line_r[0];
    word_nxt  = word_r;
    wcnt_nxt  = wcnt_r;
    busy_nxt  = busy_r;
    fin_nxt   = fin_r;
    emit_nxt  = emit_r;
    eidx_nxt  = eidx_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    osample_nxt = osample_r;
    oend_nxt    = oend_r;

    if (in_tvalid && in_tready) begin
      word_nxt = in_tdata[WORD_BITS-1:0];
      wcnt_nxt = WB_W'(WORD_BITS - 1);
      busy_nxt = 1'b1;
      fin_nxt  = in_tlast;
    end

    if (emit_r) begin
      if (slot) begin
        ovalid_nxt  = 1'b1;
        osample_nxt = unmapped;
        oend_nxt    = eidx_r == SI_W'(BLOCK_SIZE - 1);
        prev_nxt    = unmapped;
        adv         = 1'b1;
        adv_val     = line_r[0];
        eidx_nxt    = eidx_r + 1'b1;
        if (eidx_r == SI_W'(BLOCK_SIZE - 1)) emit_nxt = 1'b0;
      end
    end else if (step) begin
      word_nxt = word_r << 1;
      wcnt_nxt = wcnt_r - 1'b1;
      case (phase_r)
        PH_REF: begin
          acc_nxt = acc_sh;
          bc_nxt  = bc_r + 1'b1;
          if (bc_r + 1'b1 >= BC_W'(REF_BITS)) begin
            prev_nxt = acc_sh[SAMPLE_W-1:0] & top_mask;
            bc_nxt   = '0;
            acc_nxt  = '0;
          end
        end
        PH_CODE: begin
          acc_nxt = acc_sh;
          bc_nxt  = bc_r + 1'b1;
          if (bc_r + 1'b1 >= BC_W'(CODE_ID_BITS)) begin
            code_nxt  = acc_sh[CODE_ID_BITS-1:0];
            bc_nxt    = '0;
            acc_nxt   = '0;
            si_nxt    = '0;
            plane_nxt = '0;
            run_nxt   = '0;
          end
        end
        PH_BACKUP: begin
          acc_nxt = acc_sh;
          bc_nxt  = bc_r + 1'b1;
          if (bc_r + 1'b1 >= BC_W'(eff_w)) begin
            adv     = 1'b1;
            adv_val = acc_sh;
            bc_nxt  = '0;
            acc_nxt = '0;
            si_nxt  = si_r + 1'b1;
          end
        end
        PH_FS: begin
          if (!bit_in) begin
            if (run_r != RUN_MAX) run_nxt = run_r + 1'b1;
          end else begin
            adv     = 1'b1;
            adv_val = run_r << k;
            run_nxt = '0;
            si_nxt  = si_r + 1'b1;
            if (si_last) begin
              si_nxt    = '0;
              plane_nxt = '0;
            end
          end
        end
        PH_SPLIT: begin
          adv     = 1'b1;
          adv_val = line_r[0];
          adv_val[pos] = bit_in;
          si_nxt  = si_r + 1'b1;
          if (si_last) begin
            si_nxt    = '0;
            plane_nxt = plane_r + 1'b1;
          end
        end
        default: begin
          bc_nxt  = '0;
          acc_nxt = '0;
        end
      endcase
      if (fin_block) begin
        emit_nxt  = 1'b1;
        eidx_nxt  = '0;
        bc_nxt    = '0;
        acc_nxt   = '0;
        si_nxt    = '0;
        plane_nxt = '0;
        run_nxt   = '0;
      end
      if (wcnt_r == '0) begin
        busy_nxt = 1'b0;
        if (fin_r) begin
          bc_nxt    = '0;
          acc_nxt   = '0;
          si_nxt    = '0;
          plane_nxt = '0;
          run_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r     <= SB_RESET;
      busy_r   <= 1'b0;
      fin_r    <= 1'b0;
      wcnt_r   <= '0;
      phase_r  <= PH_REF;
      bc_r     <= '0;
      acc_r    <= '0;
      code_r   <= '0;
      si_r     <= '0;
      plane_r  <= '0;
      run_r    <= '0;
      prev_r   <= '0;
      emit_r   <= 1'b0;
      eidx_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      sb_r     <= sb_nxt;
      busy_r   <= busy_nxt;
      fin_r    <= fin_nxt;
      wcnt_r   <= wcnt_nxt;
      phase_r  <= phase_nxt;
      bc_r     <= bc_nxt;
      acc_r    <= acc_nxt;
      code_r   <= code_nxt;
      si_r     <= si_nxt;
      plane_r  <= plane_nxt;
      run_r    <= run_nxt;
      prev_r   <= prev_nxt;
      emit_r   <= emit_nxt;
      eidx_r   <= eidx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    osample_r <= osample_nxt;
    oend_r    <= oend_nxt;
    if (adv) begin
      for (int i = 0; i < BLOCK_SIZE - 1; i++) line_r[i] <= line_r[i + 1];
      line_r[BLOCK_SIZE-1] <= adv_val;
    end
  end

  `RBD_ASSERT_NOW(a_no_take_while_emit, emit_r, !in_tready)
  `RBD_ASSERT_NEXT(a_emit_ends, emit_r && slot && eidx_r == SI_W'(BLOCK_SIZE - 1),
                   !emit_r && out_tvalid && out_tuser)
  `RBD_ASSERT_NEXT(a_block_starts_emit, step && fin_block, emit_r && eidx_r == '0)

endmodule
